// ----- hdl/job_sequencing_with_deadlines_core_macros.svh -----
// Assertion macros for the checker file of the job scheduler.
`ifndef JOB_SEQUENCING_WITH_DEADLINES_CORE_MACROS_SVH
`define JOB_SEQUENCING_WITH_DEADLINES_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jsd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsd assertion failed");

`endif

// ----- hdl/jsd_pkg.sv -----
// Shared types and constants of the job scheduler.
`default_nettype none
package jsd_pkg;

  localparam int DEADLINE_W = 11;
  localparam int PROFIT_W   = 16;
  localparam int COUNT_W    = 11;
  localparam int TOTAL_W    = 26;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // One job request as it travels from the front to the back.
  typedef struct packed {
    logic                  last;
    logic [PROFIT_W-1:0]   profit;
    logic [DEADLINE_W-1:0] deadline;
  } jsd_item_t;

  // One result as it leaves the back.
  typedef struct packed {
    logic               overflow;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } jsd_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_SCAN,
    ST_MARK,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_LINK,
    ST_OUT
  } jsd_state_e;

endpackage
`default_nettype wire

// ----- hdl/jsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/jsd_front.sv -----
// Input stage: takes job requests, clamps the deadline, masks the profit.
`default_nettype none
module jsd_front #(
  parameter int MAX_DEADLINE = 1024,
  parameter int PROFIT_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire jsd_pkg::jsd_item_t item_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output jsd_pkg::jsd_item_t     item_o
);
  import jsd_pkg::*;

  localparam logic [31:0] DL_TOP = MAX_DEADLINE;
  localparam int PB = (PROFIT_BITS < PROFIT_W) ? PROFIT_BITS : PROFIT_W;
  localparam logic [PROFIT_W-1:0] P_MASK = PROFIT_W'((33'd1 << PB) - 33'd1);

  logic      vld_q, vld_d;
  jsd_item_t item_q, item_d;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign item_o  = item_q;

  // classify: saturate deadline, keep profit bits
  always_comb begin
    item_d = item_q;
    vld_d  = vld_q && !ready_i;
    if (valid_i && ready_o) begin
      vld_d           = 1'b1;
      item_d.last     = item_i.last;
      item_d.profit   = item_i.profit & P_MASK;
      item_d.deadline = ({21'd0, item_i.deadline} > DL_TOP) ?
                        DL_TOP[DEADLINE_W-1:0] : item_i.deadline;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule
`default_nettype wire

// ----- hdl/jsd_fifo.sv -----
// Four-entry request queue between front and back.
`default_nettype none
module jsd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire jsd_pkg::jsd_item_t push_item_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output jsd_pkg::jsd_item_t     pop_item_o
);
  import jsd_pkg::*;

  jsd_item_t  mem_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 3'd4);
  assign pop_valid_o  = (cnt_q != 3'd0);
  assign pop_item_o   = mem_q[rp_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointer and fill update
  always_comb begin
    wp_d  = push ? wp_q + 2'd1 : wp_q;
    rp_d  = pop ? rp_q + 2'd1 : rp_q;
    cnt_d = cnt_q + {2'd0, push} - {2'd0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/jsd_back.sv -----
// Scheduler: stores jobs, picks them by falling profit, finds slots.
`default_nettype none
module jsd_back #(
  parameter int MAX_JOBS     = 1024,
  parameter int MAX_DEADLINE = 1024,
  parameter int PROFIT_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire jsd_pkg::jsd_item_t  item_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output jsd_pkg::jsd_result_t    result_o
);
  import jsd_pkg::*;

  localparam int AW   = $clog2(MAX_JOBS);
  localparam int CW   = $clog2(MAX_JOBS + 1);
  localparam int SW   = $clog2(MAX_DEADLINE + 1);
  localparam int PB   = (PROFIT_BITS < PROFIT_W) ? PROFIT_BITS : PROFIT_W;
  localparam int JW   = 1 + SW + PB;
  localparam int SUMW = TOTAL_W + 1;
  localparam logic [SW-1:0] SLOT_TOP = SW'(MAX_DEADLINE);
  localparam logic [CW-1:0] JOBS_CAP = CW'(MAX_JOBS);

  jsd_state_e  state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic          rd_vld_q, rd_vld_d, found_q, found_d, ovf_q, ovf_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d, best_idx_q, best_idx_d;
  logic [SW-1:0] best_d_q, best_d_d, slot_q, slot_d, clr_q, clr_d;
  logic [PB-1:0] best_p_q, best_p_d;
  logic [COUNT_W-1:0] jcnt_q, jcnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic          out_vld_q, out_vld_d;
  jsd_result_t   out_q, out_d;

  logic          j_we, p_we;
  logic [AW-1:0] j_waddr, j_raddr;
  logic [JW-1:0] j_wdata, j_rdata;
  logic [SW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [SW+DEADLINE_W-1:0] d_wide;
  logic [SW-1:0] in_d;
  logic [PB-1:0] in_p, rd_p;
  logic          rd_done;
  logic [SUMW-1:0] sum;

  jsd_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_jobs (
    .clk_i, .we_i(j_we), .waddr_i(j_waddr), .wdata_i(j_wdata),
    .raddr_i(j_raddr), .rdata_o(j_rdata)
  );

  jsd_ram #(.WIDTH(SW), .DEPTH(MAX_DEADLINE + 1)) u_parent (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  assign d_wide   = {{SW{1'b0}}, item_i.deadline};
  assign in_d     = d_wide[SW-1:0];
  assign in_p     = item_i.profit[PB-1:0];
  assign rd_done  = j_rdata[JW-1];
  assign rd_p     = j_rdata[PB-1:0];
  assign sum      = {1'b0, total_q} + SUMW'(best_p_q);
  assign ready_o  = (state_q == ST_LOAD);
  assign valid_o  = out_vld_q;
  assign result_o = out_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d_d   = best_d_q;
    best_p_d   = best_p_q;
    slot_d     = slot_q;
    clr_d      = clr_q;
    ovf_d      = ovf_q;
    jcnt_d     = jcnt_q;
    total_d    = total_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !ready_i;
    j_we       = 1'b0;
    j_waddr    = best_idx_q;
    j_wdata    = {1'b1, best_d_q, best_p_q};
    j_raddr    = idx_q[AW-1:0];
    p_we       = 1'b0;
    p_waddr    = slot_q;
    p_wdata    = slot_q - SW'(1);
    p_raddr    = slot_q;
    unique case (state_q)
      ST_CLEAR: begin
        // every slot points to itself
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        if (clr_q == SLOT_TOP) begin
          state_d = ST_LOAD;
        end else begin
          clr_d = clr_q + SW'(1);
        end
      end
      ST_LOAD: begin
        if (valid_i) begin
          if (cnt_q < JOBS_CAP) begin
            j_we    = 1'b1;
            j_waddr = cnt_q[AW-1:0];
            j_wdata = {1'b0, in_d, in_p};
            cnt_d   = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.last) begin
            state_d = ST_SCAN;
            idx_d   = '0;
            found_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // stream through the store, keep the best open job
        if (idx_q < cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[AW-1:0];
          idx_d    = idx_q + CW'(1);
        end
        if (rd_vld_q && !rd_done && (!found_q || rd_p > best_p_q)) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_d_d   = j_rdata[PB +: SW];
          best_p_d   = rd_p;
        end
        if (idx_q == cnt_q && !rd_vld_q) begin
          state_d = found_q ? ST_MARK : ST_OUT;
        end
      end
      ST_MARK: begin
        j_we    = 1'b1;
        slot_d  = best_d_q;
        state_d = ST_FIND_RD;
      end
      ST_FIND_RD: begin
        state_d = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        // walk to the root
        if (p_rdata == slot_q) begin
          if (slot_q != '0) begin
            state_d = ST_LINK;
          end else begin
            state_d = ST_SCAN;
            idx_d   = '0;
            found_d = 1'b0;
          end
        end else begin
          slot_d  = p_rdata;
          state_d = ST_FIND_RD;
        end
      end
      ST_LINK: begin
        p_we    = 1'b1;
        if (jcnt_q != COUNT_MAX) begin
          jcnt_d = jcnt_q + COUNT_W'(1);
        end
        total_d = (sum > SUMW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        state_d = ST_SCAN;
        idx_d   = '0;
        found_d = 1'b0;
      end
      ST_OUT: begin
        if (!out_vld_q || ready_i) begin
          out_vld_d      = 1'b1;
          out_d.count    = jcnt_q;
          out_d.total    = total_q;
          out_d.overflow = ovf_q;
          cnt_d          = '0;
          ovf_d          = 1'b0;
          jcnt_d         = '0;
          total_d        = '0;
          clr_d          = '0;
          state_d        = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      clr_q     <= '0;
      ovf_q     <= 1'b0;
      jcnt_q    <= '0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      clr_q     <= clr_d;
      ovf_q     <= ovf_d;
      jcnt_q    <= jcnt_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_d_q   <= best_d_d;
    best_p_q   <= best_p_d;
    slot_q     <= slot_d;
    out_q      <= out_d;
  end

endmodule
`default_nettype wire

// ----- hdl/job_sequencing_with_deadlines_core.sv -----
// Top level of the job scheduler with deadlines.
// Usage:
//  - Slave stream: one job request per beat, tdata = deadline, profit;
//    tlast marks the final job of a set and starts scheduling.
//  - Master stream: one result per set, tdata = job_count, total_profit;
//    tuser = overflow (jobs beyond MAX_JOBS were dropped).
//  - Loading takes one request per cycle through a four-deep queue, but only
//    while the scheduler is in its load state.
//  - Scheduling: each pick scans the N stored jobs, marks the pick, then
//    the slot find reads and checks the parent table once per step, and a
//    found slot is linked; the run time is set mostly by the single read
//    port of the job store.
//  - After reset and after each result the parent table is swept once over
//    its MAX_DEADLINE+1 slots, during which no new job is taken from the queue.
//  - A stalled result waits in the output register; the block goes on
//    clearing and loading the next set meanwhile, and only blocks if a
//    second result is ready before the first is taken.
`default_nettype none
module job_sequencing_with_deadlines_core #(
  parameter int MAX_JOBS     = 1024,
  parameter int MAX_DEADLINE = 1024,
  parameter int PROFIT_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // deadline[10:0], profit[26:11], zero pad
  input  wire logic        s_axis_tlast,  // last_job
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,  // job_count[10:0], total_profit[36:11], pad
  output logic             m_axis_tuser   // overflow
);
  import jsd_pkg::*;

  jsd_item_t   in_item, fr_item, q_item;
  jsd_result_t res;
  logic        fr_valid, fr_ready, q_valid, q_ready;

  assign in_item.deadline = s_axis_tdata[DEADLINE_W-1:0];
  assign in_item.profit   = s_axis_tdata[DEADLINE_W +: PROFIT_W];
  assign in_item.last     = s_axis_tlast;

  jsd_front #(.MAX_DEADLINE(MAX_DEADLINE), .PROFIT_BITS(PROFIT_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready), .item_i(in_item),
    .valid_o(fr_valid), .ready_i(fr_ready), .item_o(fr_item)
  );

  jsd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(fr_valid), .push_ready_o(fr_ready), .push_item_i(fr_item),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_item_o(q_item)
  );

  jsd_back #(
    .MAX_JOBS(MAX_JOBS), .MAX_DEADLINE(MAX_DEADLINE), .PROFIT_BITS(PROFIT_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .item_i(q_item),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .result_o(res)
  );

  assign m_axis_tdata = {3'd0, res.total, res.count};
  assign m_axis_tuser = res.overflow;

endmodule
`default_nettype wire

// ----- hdl/jsd_checker.sv -----
// Port-level checker for the job scheduler, bound to the top level.
`default_nettype none
`include "job_sequencing_with_deadlines_core_macros.svh"
module jsd_checker #(
  parameter int MAX_JOBS = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  logic [10:0] cnt;
  logic [25:0] tot;
  logic        cnt_ok;

  assign cnt    = m_axis_tdata[10:0];
  assign tot    = m_axis_tdata[36:11];
  assign cnt_ok = (MAX_JOBS >= 2047) || ({21'd0, cnt} <= MAX_JOBS);

  // valid held while stalled
  `JSD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // never more scheduled than MAX_JOBS
  `JSD_ASSERT_NOW(a_count, m_axis_tvalid, cnt_ok)
  // nothing scheduled means nothing earned
  `JSD_ASSERT_NOW(a_zero, m_axis_tvalid && cnt == 11'd0, tot == 26'd0)
  // pad bits stay clear
  `JSD_ASSERT_NOW(a_pad, m_axis_tvalid, m_axis_tdata[39:37] == 3'd0)

endmodule

bind job_sequencing_with_deadlines_core jsd_checker #(.MAX_JOBS(MAX_JOBS)) u_jsd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ----- tb/sv/job_sequencing_with_deadlines_core_tb.sv -----
// Self-checking testbench for the job scheduler core: stream stimulus, greedy predictor.
`default_nettype none
module job_sequencing_with_deadlines_core_tb;
  import jsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_JOBS     = 1024;
  localparam int MAX_DEADLINE = 1024;
  localparam int STALL_LIMIT  = 12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  job_sequencing_with_deadlines_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  // Shadow job store of the set being loaded
  logic [DEADLINE_W-1:0] shadow_deadline [MAX_JOBS];
  logic [PROFIT_W-1:0]   shadow_profit [MAX_JOBS];
  int                    shadow_loaded = 0;
  bit                    shadow_overflow = 1'b0;

  jsd_result_t pending_schedules[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold_left = 0;

  // Greedy schedule of the shadow set: falling profit, latest free slot
  function automatic jsd_result_t schedule_set();
    jsd_result_t res;
    int ord [MAX_JOBS];
    bit used [MAX_DEADLINE+1];
    int key, j, s, count;
    longint sum;
    for (int i = 0; i < shadow_loaded; i++) ord[i] = i;
    for (int i = 1; i < shadow_loaded; i++) begin
      key = ord[i];
      j = i;
      while (j > 0 && shadow_profit[key] > shadow_profit[ord[j-1]]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    for (int i = 0; i <= MAX_DEADLINE; i++) used[i] = 1'b0;
    count = 0;
    sum = 0;
    for (int i = 0; i < shadow_loaded; i++) begin
      s = shadow_deadline[ord[i]];
      while (s > 0 && used[s]) s--;
      if (s > 0) begin
        used[s] = 1'b1;
        count++;
        sum += shadow_profit[ord[i]];
      end
    end
    res.count    = (count > int'(COUNT_MAX)) ? COUNT_MAX : count[COUNT_W-1:0];
    res.total    = (sum > longint'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    res.overflow = shadow_overflow;
    return res;
  endfunction

  // Book one accepted job request into the shadow store
  function automatic void load_job(int dl, int pf, bit last);
    int d;
    d = (dl > MAX_DEADLINE) ? MAX_DEADLINE : dl;
    if (shadow_loaded < MAX_JOBS) begin
      shadow_deadline[shadow_loaded] = d[DEADLINE_W-1:0];
      shadow_profit[shadow_loaded]   = pf[PROFIT_W-1:0];
      shadow_loaded++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (last) begin
      pending_schedules.insert(pending_schedules.size(), schedule_set());
      shadow_loaded = 0;
      shadow_overflow = 1'b0;
    end
  endfunction

  // Send one job request, with random idle cycles ahead of it
  task automatic send_job(int dl, int pf, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pf[PROFIT_W-1:0], dl[DEADLINE_W-1:0]};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    load_job(dl, pf, last);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (recv_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    jsd_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_schedules.size() == 0) begin
        $display("%0t: unexpected result count=%0d total=%0d ovf=%0b", $time,
                 m_axis_tdata[10:0], m_axis_tdata[36:11], m_axis_tuser);
        errors++;
      end else begin
        exp_res = pending_schedules.pop_front();
        if (m_axis_tdata[10:0] !== exp_res.count) begin
          $display("%0t: job_count expected %0d actual %0d", $time,
                   exp_res.count, m_axis_tdata[10:0]);
          errors++;
        end
        if (m_axis_tdata[36:11] !== exp_res.total) begin
          $display("%0t: total_profit expected %0d actual %0d", $time,
                   exp_res.total, m_axis_tdata[36:11]);
          errors++;
        end
        if (m_axis_tuser !== exp_res.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   exp_res.overflow, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_schedules.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, saturation, deadline zero, ties, crowded slots
  task automatic test_directed();
    send_job(1, 1, 1);
    send_job(0, 65535, 1);
    send_job(0, 5, 0);
    send_job(2047, 65535, 0);
    send_job(1024, 65535, 1);
    send_job(1025, 100, 0);
    send_job(1, 100, 0);
    send_job(1, 100, 0);
    send_job(2, 100, 1);
    send_job(3, 10, 0);
    send_job(1, 50, 0);
    send_job(2, 20, 0);
    send_job(2, 30, 0);
    send_job(3, 40, 0);
    send_job(1, 60, 1);
    send_job(1365, 43690, 0);
    send_job(682, 21845, 0);
    send_job(1, 65535, 1);
  endtask

  // More jobs than the store holds: extras dropped and flagged
  task automatic test_store_full();
    for (int i = 0; i < MAX_JOBS + 2; i++)
      send_job($urandom_range(1, 1024), $urandom_range(1, 65535), i == MAX_JOBS + 1);
  endtask

  // Random sets, mostly small with crowded deadlines
  task automatic test_random_sets(int n_items);
    int sent, n, dmax, pmax, dl;
    sent = 0;
    while (sent < n_items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      dmax = ($urandom_range(3) == 0) ? 2047 : $urandom_range(1, 12);
      pmax = ($urandom_range(3) == 0) ? 8 : 65535;
      for (int i = 0; i < n; i++) begin
        dl = $urandom_range(0, dmax);
        if (dmax != 2047 && dl == 0 && $urandom_range(3) != 0) dl = 1;
        send_job(dl, $urandom_range(1, pmax), i == n - 1);
      end
      sent += n;
    end
  endtask

  // Receiver holds off long while sets keep coming, so the input stalls
  task automatic test_result_holdoff();
    recv_hold_left = 5000;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 3; i++)
        send_job($urandom_range(1, 4), $urandom_range(1, 65535), i == 2);
  endtask

  // Sender pauses until every result has come, then one more set
  task automatic test_drain_pause();
    idle_sender();
    wait_drained();
    repeat (40) @(posedge clk_i);
    send_job(2, 7, 0);
    send_job(2, 9, 1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 27;
    recv_idle_pct = 79;
    test_directed();
    test_random_sets(600);
    test_result_holdoff();
    send_idle_pct = 79;
    recv_idle_pct = 27;
    test_random_sets(100);
    test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_store_full();
    test_random_sets(100);
    idle_sender();
    wait_drained();
    repeat (2000) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
